[sv/ebsc_pkg.sv]
// shared types, constants and cosine table for the emergency brake scan check
`timescale 1ns / 1ps

package ebsc_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int COS_ADDR_BITS = 8;
   localparam int FRAC_BITS     = ANGLE_BITS - 2;
   localparam int ROM_SIZE      = 1 << COS_ADDR_BITS;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [15:0] RST_TTC_THRESHOLD_MS      = 16'd500;
   localparam logic [15:0] RST_DISTANCE_THRESHOLD_MM = 16'd300;
   localparam logic [15:0] RST_RANGE_FLOOR_MM        = 16'd0;
   localparam logic [15:0] RST_RANGE_CEILING_MM      = 16'd65534;
   localparam logic [15:0] RST_ANGLE_START           = 16'd0;
   localparam logic [15:0] RST_ANGLE_STEP            = 16'd0;
   localparam logic [15:0] NO_RANGE_MM               = 16'hFFFF;

   localparam longint PI_HALF_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30     = 64'sd1 <<< 30;

   typedef enum logic [1:0] {
      OP_SPEED   = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_ENGAGE  = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TTC_THRESHOLD      = 3'd0,
      CSR_DISTANCE_THRESHOLD = 3'd1,
      CSR_RANGE_FLOOR        = 3'd2,
      CSR_RANGE_CEILING      = 3'd3,
      CSR_ANGLE_START        = 3'd4,
      CSR_ANGLE_STEP         = 3'd5
   } csr_type;

   typedef struct packed {
      logic [15:0] ttc_threshold_ms;
      logic [15:0] distance_threshold_mm;
      logic [15:0] range_floor_mm;
      logic [15:0] range_ceiling_mm;
      logic [15:0] angle_start;
      logic [15:0] angle_step;
   } cfg_type;

   typedef struct packed {
      op_type      opcode;
      logic [15:0] speed_mm_s;
      logic [15:0] range_mm;
      logic        range_ok;
      logic        last_in_scan;
   } item_type;

   typedef struct packed {
      logic        brake_active;
      logic        ttc_hit;
      logic        distance_hit;
      logic [15:0] closest_mm;
      logic        state_changed;
   } result_type;

   typedef logic [15:0] rom_type [ROM_SIZE];

   function automatic longint taylor_div(longint p, int n);
      case (n)
         7:       return p / 182;
         6:       return p / 132;
         5:       return p / 90;
         4:       return p / 56;
         3:       return p / 30;
         2:       return p / 12;
         1:       return p / 2;
         default: return p;
      endcase
   endfunction

   function automatic logic [15:0] cos_entry(int k);
      longint x;
      longint x2;
      longint t;
      longint p;
      x  = (PI_HALF_Q30 * longint'(k)) >>> COS_ADDR_BITS;
      x2 = (x * x) >>> 30;
      t  = ONE_Q30;
      for (int n = 7; n >= 1; n--) begin
         p = (x2 * t) >>> 30;
         t = ONE_Q30 - taylor_div(p, n);
         if (t < 0) begin
            t = 0;
         end
      end
      t = (t + (64'sd1 <<< 14)) >>> 15;
      if (t > 32767) begin
         t = 32767;
      end
      return 16'(t);
   endfunction

   function automatic rom_type build_cos_rom();
      rom_type rom;
      for (int k = 0; k < ROM_SIZE; k++) begin
         rom[k] = cos_entry(k);
      end
      return rom;
   endfunction

   localparam rom_type COS_ROM = build_cos_rom();

endpackage

[sv/ebsc_cos_lookup.sv]
// quarter-wave cosine lookup from a turn phase
`timescale 1ns / 1ps

module ebsc_cos_lookup (
   input  logic [ebsc_pkg::ANGLE_BITS-1:0] angle,
   output logic signed [15:0]              cos_val
);

   logic [1:0]                        quad;
   logic [ebsc_pkg::FRAC_BITS-1:0]     frac;
   logic [ebsc_pkg::COS_ADDR_BITS-1:0] idx;
   logic [ebsc_pkg::COS_ADDR_BITS-1:0] rom_addr;
   logic [15:0]                        mag;
   logic                               negate;

   assign quad = angle[ebsc_pkg::ANGLE_BITS-1 -: 2];
   assign frac = angle[ebsc_pkg::FRAC_BITS-1:0];

   generate
      if (ebsc_pkg::FRAC_BITS >= ebsc_pkg::COS_ADDR_BITS) begin : g_trunc
         assign idx = frac[ebsc_pkg::FRAC_BITS-1 -: ebsc_pkg::COS_ADDR_BITS];
      end else begin : g_widen
         assign idx = {frac, {(ebsc_pkg::COS_ADDR_BITS - ebsc_pkg::FRAC_BITS){1'b0}}};
      end
   endgenerate

   // odd quadrants read the mirrored entry as a sine
   always_comb begin
      rom_addr = quad[0] ? ({ebsc_pkg::COS_ADDR_BITS{1'b0}} - idx) : idx;
      if (quad[0] && (idx == '0)) begin
         mag = 16'd0;
      end else begin
         mag = ebsc_pkg::COS_ROM[rom_addr];
      end
      negate  = quad[1] ^ quad[0];
      cos_val = negate ? -$signed(mag) : $signed(mag);
   end

endmodule

[sv/ebsc_csr.sv]
// configuration registers of the emergency brake scan check
`timescale 1ns / 1ps

module ebsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [ebsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ebsc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output ebsc_pkg::cfg_type                cfg
);

   ebsc_pkg::cfg_type cfg_ff;
   ebsc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            ebsc_pkg::CSR_TTC_THRESHOLD:      cfg_in.ttc_threshold_ms      = csr_wdata;
            ebsc_pkg::CSR_DISTANCE_THRESHOLD: cfg_in.distance_threshold_mm = csr_wdata;
            ebsc_pkg::CSR_RANGE_FLOOR:        cfg_in.range_floor_mm        = csr_wdata;
            ebsc_pkg::CSR_RANGE_CEILING:      cfg_in.range_ceiling_mm      = csr_wdata;
            ebsc_pkg::CSR_ANGLE_START:        cfg_in.angle_start           = csr_wdata;
            ebsc_pkg::CSR_ANGLE_STEP:         cfg_in.angle_step            = csr_wdata;
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ttc_threshold_ms      <= ebsc_pkg::RST_TTC_THRESHOLD_MS;
         cfg_ff.distance_threshold_mm <= ebsc_pkg::RST_DISTANCE_THRESHOLD_MM;
         cfg_ff.range_floor_mm        <= ebsc_pkg::RST_RANGE_FLOOR_MM;
         cfg_ff.range_ceiling_mm      <= ebsc_pkg::RST_RANGE_CEILING_MM;
         cfg_ff.angle_start           <= ebsc_pkg::RST_ANGLE_START;
         cfg_ff.angle_step            <= ebsc_pkg::RST_ANGLE_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/ebsc_scan_core.sv]
// scan accumulators, time-to-collision compare and brake decision
`timescale 1ns / 1ps

module ebsc_scan_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  ebsc_pkg::item_type     item,
   input  ebsc_pkg::cfg_type      cfg,
   output logic                   has_result,
   output ebsc_pkg::result_type   result
);

   logic signed [32:0]                speed_product_ff, speed_product_in;
   logic [ebsc_pkg::ANGLE_BITS-1:0]   angle_offset_ff, angle_offset_in;
   logic [15:0]                       closest_ff, closest_in;
   logic                              ttc_seen_ff, ttc_seen_in;
   logic                              brake_ff, brake_in;

   logic [ebsc_pkg::ANGLE_BITS-1:0]   angle;
   logic signed [15:0]                cos_val;
   logic [25:0]                       range_x1000;
   logic signed [48:0]                lhs;
   logic signed [48:0]                prod;
   logic                              in_window;
   logic [15:0]                       closest_now;
   logic                              ttc_now;
   logic                              dist_hit;

   assign angle = ebsc_pkg::ANGLE_BITS'(cfg.angle_start) + angle_offset_ff;

   ebsc_cos_lookup u_cos (
      .angle   (angle),
      .cos_val (cos_val)
   );

   assign range_x1000 = 26'(item.range_mm) * 26'd1000;
   assign lhs         = $signed({8'b0, range_x1000, 15'b0});
   assign prod        = speed_product_ff * cos_val;

   always_comb begin
      speed_product_in = speed_product_ff;
      angle_offset_in  = angle_offset_ff;
      closest_in       = closest_ff;
      ttc_seen_in      = ttc_seen_ff;
      brake_in         = brake_ff;
      has_result       = 1'b0;
      result           = '0;

      in_window = item.range_ok && (item.range_mm >= cfg.range_floor_mm)
                  && (item.range_mm <= cfg.range_ceiling_mm);
      closest_now = (in_window && (item.range_mm < closest_ff)) ? item.range_mm : closest_ff;
      ttc_now     = ttc_seen_ff || (in_window && (lhs < prod));
      dist_hit    = closest_now < cfg.distance_threshold_mm;

      unique case (item.opcode)
         ebsc_pkg::OP_SPEED: begin
            speed_product_in = $signed({1'b0, cfg.ttc_threshold_ms})
                               * $signed(item.speed_mm_s);
         end
         ebsc_pkg::OP_SAMPLE: begin
            if (item.last_in_scan) begin
               brake_in             = ttc_now || dist_hit;
               has_result           = 1'b1;
               result.brake_active  = brake_in;
               result.ttc_hit       = ttc_now;
               result.distance_hit  = dist_hit;
               result.closest_mm    = closest_now;
               result.state_changed = brake_in != brake_ff;
               closest_in           = ebsc_pkg::NO_RANGE_MM;
               ttc_seen_in          = 1'b0;
               angle_offset_in      = '0;
            end else begin
               closest_in      = closest_now;
               ttc_seen_in     = ttc_now;
               angle_offset_in = angle_offset_ff + ebsc_pkg::ANGLE_BITS'(cfg.angle_step);
            end
         end
         ebsc_pkg::OP_ENGAGE, ebsc_pkg::OP_RELEASE: begin
            brake_in             = item.opcode == ebsc_pkg::OP_ENGAGE;
            has_result           = 1'b1;
            result.brake_active  = brake_in;
            result.closest_mm    = ebsc_pkg::NO_RANGE_MM;
            result.state_changed = brake_in != brake_ff;
         end
         default: has_result = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_product_ff <= '0;
         angle_offset_ff  <= '0;
         closest_ff       <= ebsc_pkg::NO_RANGE_MM;
         ttc_seen_ff      <= 1'b0;
         brake_ff         <= 1'b0;
      end else if (fire) begin
         speed_product_ff <= speed_product_in;
         angle_offset_ff  <= angle_offset_in;
         closest_ff       <= closest_in;
         ttc_seen_ff      <= ttc_seen_in;
         brake_ff         <= brake_in;
      end
   end

endmodule

[sv/emergency_brake_scan_check_top.sv]
// top level of the emergency brake scan check
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  opcode, speed, range, range_ok, last
//   rsp      out        rsp_valid / rsp_stall  brake, ttc hit, distance hit, closest, changed
//   csr      in         csr_write              csr_index, csr_wdata
//
// one word per cycle while req_stall is low; a word with a result passes the input register,
// then one pass through lookup, multiply and compare into the result register
// synchronous reset restores the register defaults and clears the scan state at once
// rsp_stall holds the result register and raises req_stall once the input register is full
`timescale 1ns / 1ps

module emergency_brake_scan_check_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic signed [15:0]               req_speed_mm_s,
   input  logic [15:0]                      req_range_mm,
   input  logic                             req_range_ok,
   input  logic                             req_last_in_scan,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_brake_active,
   output logic                             rsp_ttc_hit,
   output logic                             rsp_distance_hit,
   output logic [15:0]                      rsp_closest_mm,
   output logic                             rsp_state_changed,
   input  logic                             csr_write,
   input  logic [ebsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ebsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ebsc_pkg::cfg_type    cfg;
   ebsc_pkg::item_type   in_word_ff, in_word_in;
   logic                 in_valid_ff, in_valid_in;
   ebsc_pkg::result_type out_word_ff;
   logic                 out_valid_ff, out_valid_in;
   ebsc_pkg::result_type result;
   logic                 has_result;
   logic                 advance;
   logic                 fire;
   logic                 req_take;

   ebsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_word_in.opcode       = ebsc_pkg::op_type'(req_opcode);
      in_word_in.speed_mm_s   = req_speed_mm_s;
      in_word_in.range_mm     = req_range_mm;
      in_word_in.range_ok     = req_range_ok;
      in_word_in.last_in_scan = req_last_in_scan;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = advance ? fire && has_result : out_valid_ff;
   end

   ebsc_scan_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_word_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= in_word_in;
      end
      if (fire && has_result) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_brake_active  = out_word_ff.brake_active;
   assign rsp_ttc_hit       = out_word_ff.ttc_hit;
   assign rsp_distance_hit  = out_word_ff.distance_hit;
   assign rsp_closest_mm    = out_word_ff.closest_mm;
   assign rsp_state_changed = out_word_ff.state_changed;

endmodule

[sv/ebsc_checker.sv]
// port-level checks for the emergency brake scan check
`timescale 1ns / 1ps

module ebsc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_brake_active,
   input  logic                             rsp_ttc_hit,
   input  logic                             rsp_distance_hit,
   input  logic [15:0]                      rsp_closest_mm,
   input  logic                             rsp_state_changed
);

   logic last_brake_ff;

   // brake state as last shown on the result channel
   always_ff @(posedge clock) begin
      if (reset) begin
         last_brake_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         last_brake_ff <= rsp_brake_active;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_closest_mm)
      && $stable(rsp_brake_active))
      else $error("stalled result word changed");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_state_changed == (rsp_brake_active != last_brake_ff))
      else $error("state_changed disagrees with previous brake state");

   a_hit_implies_brake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ttc_hit || rsp_distance_hit) |-> rsp_brake_active)
      else $error("hit reported without braking");

   a_distance_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance_hit |-> rsp_closest_mm != ebsc_pkg::NO_RANGE_MM)
      else $error("distance hit with no valid range");

endmodule

bind emergency_brake_scan_check_top ebsc_checker u_ebsc_checker (.*);

[bench/decision_check.sv]
// checker for the emergency brake scan check: predicts each brake decision and compares results
`timescale 1ns / 1ps

module decision_check
   import ebsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic signed [15:0]     req_speed_mm_s,
   input  logic [15:0]            req_range_mm,
   input  logic                   req_range_ok,
   input  logic                   req_last_in_scan,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_brake_active,
   input  logic                   rsp_ttc_hit,
   input  logic                   rsp_distance_hit,
   input  logic [15:0]            rsp_closest_mm,
   input  logic                   rsp_state_changed,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     decisions_pending
);

   logic [15:0]            cos_table [ROM_SIZE];
   cfg_type                cfg;
   logic signed [32:0]     speed_product;
   logic [ANGLE_BITS-1:0]  angle_offset;
   logic [15:0]            closest_so_far;
   logic                   ttc_seen;
   logic                   brake_on;
   result_type             decision_queue [$];

   // quarter-wave cosine in q1.15 from a truncating taylor series in q2.30
   function automatic logic [15:0] q15_cos(int k);
      longint x;
      longint x2;
      longint t;
      x  = (PI_HALF_Q30 * longint'(k)) >>> COS_ADDR_BITS;
      x2 = (x * x) >>> 30;
      t  = ONE_Q30;
      for (int n = 7; n >= 1; n--) begin
         t = ONE_Q30 - ((x2 * t) >>> 30) / longint'((2 * n) * (2 * n - 1));
         if (t < 0) begin
            t = 0;
         end
      end
      t = (t + (longint'(1) <<< 14)) >>> 15;
      if (t > 32767) begin
         t = 32767;
      end
      return t[15:0];
   endfunction

   function automatic longint cos_at(logic [ANGLE_BITS-1:0] a);
      logic [1:0]               quad;
      logic [COS_ADDR_BITS-1:0] idx;
      longint                   c;
      longint                   s;
      quad = a[ANGLE_BITS-1 -: 2];
      idx  = a[ANGLE_BITS-3 -: COS_ADDR_BITS];
      c    = longint'(cos_table[idx]);
      s    = (idx == 0) ? 0 : longint'(cos_table[ROM_SIZE - int'(idx)]);
      case (quad)
         2'd0:    return c;
         2'd1:    return -s;
         2'd2:    return -c;
         default: return s;
      endcase
   endfunction

   function automatic void predict_word(item_type w);
      logic        brake_prior;
      logic        dist_hit;
      longint      lhs;
      logic [15:0] angle;
      brake_prior = brake_on;
      case (w.opcode)
         OP_SPEED: begin
            speed_product = 33'(longint'(cfg.ttc_threshold_ms) *
                                longint'($signed(w.speed_mm_s)));
         end
         OP_ENGAGE, OP_RELEASE: begin
            brake_on = (w.opcode == OP_ENGAGE);
            decision_queue.push_back({brake_on, 1'b0, 1'b0, NO_RANGE_MM,
                                      brake_on != brake_prior});
         end
         default: begin
            if (w.range_ok && w.range_mm >= cfg.range_floor_mm &&
                w.range_mm <= cfg.range_ceiling_mm) begin
               angle = cfg.angle_start + angle_offset;
               lhs   = longint'(w.range_mm) * 1000 * 32768;
               if (w.range_mm < closest_so_far) begin
                  closest_so_far = w.range_mm;
               end
               if (lhs < longint'(speed_product) * cos_at(angle)) begin
                  ttc_seen = 1'b1;
               end
            end
            angle_offset = angle_offset + cfg.angle_step;
            if (w.last_in_scan) begin
               dist_hit = closest_so_far < cfg.distance_threshold_mm;
               brake_on = ttc_seen || dist_hit;
               decision_queue.push_back({brake_on, ttc_seen, dist_hit, closest_so_far,
                                         brake_on != brake_prior});
               closest_so_far = NO_RANGE_MM;
               ttc_seen       = 1'b0;
               angle_offset   = '0;
            end
         end
      endcase
   endfunction

   function automatic void note_mismatch(string what, result_type want, result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected brake %0b ttc %0b dist %0b closest %0d changed %0b,",
                  $time, what, want.brake_active, want.ttc_hit, want.distance_hit,
                  want.closest_mm, want.state_changed);
         $display("   got brake %0b ttc %0b dist %0b closest %0d changed %0b",
                  got.brake_active, got.ttc_hit, got.distance_hit, got.closest_mm,
                  got.state_changed);
      end
   endfunction

   initial begin
      for (int k = 0; k < ROM_SIZE; k++) begin
         cos_table[k] = q15_cos(k);
      end
      mismatch_count    = 0;
      decisions_pending = 0;
   end

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         cfg            = '{RST_TTC_THRESHOLD_MS, RST_DISTANCE_THRESHOLD_MM,
                            RST_RANGE_FLOOR_MM, RST_RANGE_CEILING_MM,
                            RST_ANGLE_START, RST_ANGLE_STEP};
         speed_product  = '0;
         angle_offset   = '0;
         closest_so_far = NO_RANGE_MM;
         ttc_seen       = 1'b0;
         brake_on       = 1'b0;
         decision_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_brake_active, rsp_ttc_hit, rsp_distance_hit, rsp_closest_mm,
                   rsp_state_changed};
            if (decision_queue.size() == 0) begin
               note_mismatch("unexpected word", '0, got);
            end else begin
               want = decision_queue.pop_front();
               if (got !== want) begin
                  note_mismatch("wrong word", want, got);
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_TTC_THRESHOLD:      cfg.ttc_threshold_ms      = csr_wdata;
               CSR_DISTANCE_THRESHOLD: cfg.distance_threshold_mm = csr_wdata;
               CSR_RANGE_FLOOR:        cfg.range_floor_mm        = csr_wdata;
               CSR_RANGE_CEILING:      cfg.range_ceiling_mm      = csr_wdata;
               CSR_ANGLE_START:        cfg.angle_start           = csr_wdata;
               CSR_ANGLE_STEP:         cfg.angle_step            = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_word({op_type'(req_opcode), req_speed_mm_s, req_range_mm,
                          req_range_ok, req_last_in_scan});
         end
      end
      decisions_pending = decision_queue.size();
   end

endmodule

[bench/tb_emergency_brake_scan_check_top.sv]
// testbench top for the emergency brake scan check: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_emergency_brake_scan_check_top;
   import ebsc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int WORDS_PER_ROUND = 100;
   localparam int ROUNDS = 6;
   // unmapped register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_opcode = '0;
   logic signed [15:0]     req_speed_mm_s = '0;
   logic [15:0]            req_range_mm = '0;
   logic                   req_range_ok = 1'b0;
   logic                   req_last_in_scan = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_brake_active;
   logic                   rsp_ttc_hit;
   logic                   rsp_distance_hit;
   logic [15:0]            rsp_closest_mm;
   logic                   rsp_state_changed;
   logic                   csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int decisions_pending;
   int words_sent = 0;
   int burst_left = 0;
   bit long_hold_req = 1'b0;

   emergency_brake_scan_check_top dut (.*);

   decision_check brake_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic item_type make_word(op_type op, logic [15:0] spd, logic [15:0] rng,
                                          logic ok, logic last);
      item_type w;
      w.opcode       = op;
      w.speed_mm_s   = spd;
      w.range_mm     = rng;
      w.range_ok     = ok;
      w.last_in_scan = last;
      return w;
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 7))
         0:       return 16'($urandom);
         1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         default: return 16'($urandom_range(0, 20000));
      endcase
   endfunction

   function automatic logic [15:0] pick_range();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 6000));
      endcase
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.ttc_threshold_ms      = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 3000));
      c.distance_threshold_mm = 16'($urandom_range(0, 3000));
      c.range_floor_mm        = 16'($urandom_range(0, 400));
      c.range_ceiling_mm      = 16'($urandom_range(3000, 65535));
      c.angle_start           = 16'($urandom);
      c.angle_step            = 16'($urandom);
      return c;
   endfunction

   task automatic send_word(input item_type w);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_opcode       <= w.opcode;
      req_speed_mm_s   <= w.speed_mm_s;
      req_range_mm     <= w.range_mm;
      req_range_ok     <= w.range_ok;
      req_last_in_scan <= w.last_in_scan;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // bursts of random length separated by random gaps
   task automatic offer(input item_type w);
      int gap;
      send_word(w);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 6);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decisions_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(CSR_TTC_THRESHOLD, c.ttc_threshold_ms);
      write_reg(CSR_DISTANCE_THRESHOLD, c.distance_threshold_mm);
      write_reg(CSR_RANGE_FLOOR, c.range_floor_mm);
      write_reg(CSR_RANGE_CEILING, c.range_ceiling_mm);
      write_reg(CSR_ANGLE_START, c.angle_start);
      write_reg(CSR_ANGLE_STEP, c.angle_step);
   endtask

   function automatic item_type manual_word();
      return make_word($urandom_range(0, 1) ? OP_ENGAGE : OP_RELEASE, 16'($urandom),
                       16'($urandom), 1'($urandom), 1'($urandom));
   endfunction

   task automatic random_scan();
      int len;
      if ($urandom_range(0, 2) != 0) begin
         offer(make_word(OP_SPEED, pick_speed(), 16'($urandom), 1'($urandom), 1'($urandom)));
      end
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            offer(manual_word());
         end
         offer(make_word(OP_SAMPLE, 16'($urandom), pick_range(),
                         $urandom_range(0, 9) != 0, i == len - 1));
      end
   endtask

   task automatic directed_words();
      offer(make_word(OP_RELEASE, 16'h0000, 16'h0000, 1'b0, 1'b0));
      offer(make_word(OP_ENGAGE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
      offer(make_word(OP_ENGAGE, 16'h0000, 16'h0000, 1'b0, 1'b0));
      offer(make_word(OP_RELEASE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
      offer(make_word(OP_SPEED, 16'h7FFF, 16'h0000, 1'b0, 1'b0));
      // just above and at the ceiling
      offer(make_word(OP_SAMPLE, 16'h0000, 16'hFFFF, 1'b1, 1'b1));
      offer(make_word(OP_SAMPLE, 16'h0000, 16'hFFFE, 1'b1, 1'b1));
      // flagged bad sample, then a zero range
      offer(make_word(OP_SAMPLE, 16'h0000, 16'h0000, 1'b0, 1'b0));
      offer(make_word(OP_SAMPLE, 16'h0000, 16'h0000, 1'b1, 1'b1));
      offer(make_word(OP_SPEED, 16'h8000, 16'h0000, 1'b0, 1'b0));
      offer(make_word(OP_SAMPLE, 16'h0000, 16'd100, 1'b1, 1'b1));
      // distance threshold boundary
      offer(make_word(OP_SPEED, 16'h0000, 16'h0000, 1'b0, 1'b0));
      offer(make_word(OP_SAMPLE, 16'h0000, 16'd299, 1'b1, 1'b0));
      offer(make_word(OP_SAMPLE, 16'h0000, 16'd300, 1'b1, 1'b1));
      // manual command in the middle of a scan
      offer(make_word(OP_SAMPLE, 16'h0000, 16'd5000, 1'b1, 1'b0));
      offer(make_word(OP_ENGAGE, 16'h0000, 16'h0000, 1'b0, 1'b0));
      offer(make_word(OP_SAMPLE, 16'h0000, 16'd6000, 1'b1, 1'b1));
      // one sample per quadrant, including the quadrant boundaries
      settle();
      write_reg(CSR_TTC_THRESHOLD, 16'hFFFF);
      write_reg(CSR_ANGLE_STEP, 16'h4000);
      offer(make_word(OP_SPEED, 16'h8000, 16'h0000, 1'b0, 1'b0));
      for (int q = 0; q < 4; q++) begin
         offer(make_word(OP_SAMPLE, 16'h0000, 16'd40000, 1'b1, q == 3));
      end
   endtask

   // receiver stalls on a changing pattern, with one long hold-off
   initial begin : receiver
      int hold_left;
      int mode_left;
      int mode;
      bit hold_done;
      hold_left = 0;
      mode_left = 0;
      mode      = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 199;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      cfg_type c;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      directed_words();
      for (int round = 0; round < ROUNDS; round++) begin
         settle();
         case (round)
            0: c = '{RST_TTC_THRESHOLD_MS, RST_DISTANCE_THRESHOLD_MM, RST_RANGE_FLOOR_MM,
                     RST_RANGE_CEILING_MM, RST_ANGLE_START, RST_ANGLE_STEP};
            2: c = '1;
            3: c = '0;
            default: c = random_config();
         endcase
         load_config(c);
         if (round == ROUNDS - 1) begin
            write_reg(CSR_SPARE_A, 16'($urandom));
            write_reg(CSR_SPARE_B, 16'($urandom));
         end
         if (round == 1) begin
            long_hold_req = 1'b1;
         end
         while (words_sent < (round + 1) * WORDS_PER_ROUND) begin
            if ($urandom_range(0, 9) < 8) begin
               random_scan();
            end else begin
               offer(make_word(op_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                               1'($urandom), 1'($urandom)));
            end
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (decisions_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && decisions_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
